[hw/rtl/ffha_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants for the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffha_pkg;

  localparam int FIELD_BITS            = 24;
  localparam int DEF_MAX_SEGMENTS      = 64;
  localparam int DEF_OFFSET_BITS       = 24;
  localparam int DEF_HEADER_BYTES      = 24;
  localparam int DEF_MIN_PAYLOAD_BYTES = 16;
  localparam int ALIGN_BITS            = 3;
  localparam int ALIGN_BYTES           = 1 << ALIGN_BITS;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_RESIZE = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ZERO    = 2'd1,
    ST_NOMEM   = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_INIT, S_SCAN_RD, S_SCAN_EV, S_SHU_RD, S_SHU_WR,
    S_SPLIT, S_MARK, S_FIND_START, S_FIND_RD, S_FIND_EV, S_PREV_RD,
    S_PREV_EV, S_NEXT_RD, S_NEXT_EV, S_MERGE_WR, S_SHD_RD, S_SHD_WR,
    S_SHD_END, S_DONE
  } ctl_state_t;

  typedef enum logic [4:0] {
    DP_IDLE, DP_LOAD, DP_DECODE, DP_INIT, DP_SCAN_RD, DP_SCAN_EV, DP_SHU_RD,
    DP_SHU_WR, DP_SPLIT, DP_MARK, DP_FIND_START, DP_FIND_RD, DP_FIND_EV,
    DP_PREV_RD, DP_PREV_EV, DP_NEXT_RD, DP_NEXT_EV, DP_MERGE_WR, DP_SHD_RD,
    DP_SHD_WR, DP_SHD_END, DP_PUBLISH
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic alloc_path;
    logic req_zero;
    logic present;
    logic heap_ready;
    logic init_ok;
    logic count_zero;
    logic scan_hit;
    logic split_ok;
    logic is_last;
    logic shu_more;
    logic find_hit;
    logic fits;
    logic moving;
    logic has_prev;
    logic has_next;
    logic shd_first;
    logic shd_more;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

[hw/rtl/ffha_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_if
// Request and response channels of the heap allocator.
// ----------------------------------------------------------------------------
interface ffha_req_if import ffha_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [1:0]            operation;
  logic [FIELD_BITS-1:0] request_bytes;
  logic                  block_present;
  logic [FIELD_BITS-1:0] block_offset;

  modport source (output valid, operation, request_bytes, block_present, block_offset,
                  input ready);
  modport sink   (input valid, operation, request_bytes, block_present, block_offset,
                  output ready);
endinterface

interface ffha_rsp_if import ffha_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [1:0]            status;
  logic [FIELD_BITS-1:0] payload_offset;
  logic                  moved;
  logic [FIELD_BITS-1:0] copy_bytes;

  modport source (output valid, status, payload_offset, moved, copy_bytes, input ready);
  modport sink   (input valid, status, payload_offset, moved, copy_bytes, output ready);
endinterface
`default_nettype wire

[hw/rtl/ffha_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_dp
// Datapath: segment memory, table registers, arithmetic and result words.
// ----------------------------------------------------------------------------
module ffha_dp import ffha_pkg::*; #(
  parameter int MAX_SEGMENTS      = DEF_MAX_SEGMENTS,
  parameter int OFFSET_BITS       = DEF_OFFSET_BITS,
  parameter int HEADER_BYTES      = DEF_HEADER_BYTES,
  parameter int MIN_PAYLOAD_BYTES = DEF_MIN_PAYLOAD_BYTES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dp_cmd_t               cmd,
  output dp_status_t            sts,
  input  logic                  cfg_we,
  input  logic [FIELD_BITS-1:0] cfg_data,
  input  logic [1:0]            in_operation,
  input  logic [FIELD_BITS-1:0] in_request_bytes,
  input  logic                  in_block_present,
  input  logic [FIELD_BITS-1:0] in_block_offset,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_status,
  output logic [FIELD_BITS-1:0] out_payload_offset,
  output logic                  out_moved,
  output logic [FIELD_BITS-1:0] out_copy_bytes
);

  localparam int OW = OFFSET_BITS;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int XW = CW + 2;
  localparam int BW = ((OW > FIELD_BITS) ? OW : FIELD_BITS) + 3;
  localparam int EW = 2 * OW + 1;
  localparam logic [BW-1:0] HDR_B = BW'(HEADER_BYTES);
  localparam logic [BW-1:0] MIN_B = BW'(MIN_PAYLOAD_BYTES);

  // entry layout: {start, size, free}
  logic [EW-1:0] mem [MAX_SEGMENTS];
  logic [EW-1:0] rdata;
  logic          mem_we, mem_re;
  logic [IW-1:0] mem_wa, mem_ra;
  logic [EW-1:0] mem_wd;

  logic                  heap_ready;
  logic [FIELD_BITS-1:0] heap_bytes;
  logic [CW-1:0]         count;
  logic [CW-1:0]         i, k, idx, widx;
  logic [1:0]            d;
  op_t                   op_r;
  logic [FIELD_BITS-1:0] req_r, boff_r;
  logic                  pres_r;
  logic [BW-1:0]         need_r;
  logic [OW-1:0]         hit_start, hit_size, base_start, acc, old_size;
  logic                  split_r, moving;
  status_t               status_r;
  logic [FIELD_BITS-1:0] pay_r, copy_r;
  logic                  moved_r;

  logic [OW-1:0] rd_start, rd_size;
  logic          rd_free;
  logic [BW-1:0] need_sum, rd_pay_b, hit_pay_b, hit_pay_x, merge_sum;
  logic [BW-1:0] split_start_b, split_size_b, init_size_b, copy_b;
  logic [OW-1:0] rd_pay_ow, hit_pay_ow, mark_size;
  logic [CW-1:0] ip1, km1, kpd, idx_m1, idx_p1;

  assign rd_start = rdata[EW-1 -: OW];
  assign rd_size  = rdata[OW:1];
  assign rd_free  = rdata[0];

  assign need_sum      = BW'(in_request_bytes) + BW'(ALIGN_BYTES - 1);
  assign rd_pay_b      = BW'(rd_start) + HDR_B;
  assign rd_pay_ow     = rd_pay_b[OW-1:0];
  assign hit_pay_b     = BW'(hit_start) + HDR_B;
  assign hit_pay_ow    = hit_pay_b[OW-1:0];
  assign hit_pay_x     = BW'(hit_pay_ow);
  assign merge_sum     = BW'(rd_size) + HDR_B + BW'(acc);
  assign split_start_b = BW'(hit_start) + HDR_B + need_r;
  assign split_size_b  = BW'(hit_size) - need_r - HDR_B;
  assign init_size_b   = BW'(heap_bytes) - HDR_B;
  assign copy_b        = (BW'(old_size) < BW'(req_r)) ? BW'(old_size) : BW'(req_r);
  assign mark_size     = split_r ? need_r[OW-1:0] : hit_size;

  assign ip1    = i + CW'(1);
  assign km1    = k - CW'(1);
  assign kpd    = k + CW'(d);
  assign idx_m1 = idx - CW'(1);
  assign idx_p1 = idx + CW'(1);

  // status to the controller
  assign sts.op         = op_r;
  assign sts.alloc_path = (op_r == OP_ALLOC) || ((op_r == OP_RESIZE) && !pres_r);
  assign sts.req_zero   = (req_r == '0);
  assign sts.present    = pres_r;
  assign sts.heap_ready = heap_ready;
  assign sts.init_ok    = BW'(heap_bytes) > HDR_B;
  assign sts.count_zero = (count == '0);
  assign sts.scan_hit   = rd_free && (BW'(rd_size) >= need_r);
  assign sts.split_ok   = (BW'(rd_size) >= need_r + HDR_B + MIN_B) &&
                          (count < CW'(MAX_SEGMENTS));
  assign sts.is_last    = (XW'(i) + XW'(1)) >= XW'(count);
  assign sts.shu_more   = XW'(k) > (XW'(i) + XW'(2));
  assign sts.find_hit   = (BW'(rd_pay_ow) == BW'(boff_r));
  assign sts.fits       = BW'(rd_size) >= BW'(req_r);
  assign sts.moving     = moving;
  assign sts.has_prev   = (idx != '0);
  assign sts.has_next   = (XW'(idx) + XW'(1)) < XW'(count);
  assign sts.shd_first  = (XW'(widx) + XW'(1) + XW'(d)) < XW'(count);
  assign sts.shd_more   = (XW'(k) + XW'(1) + XW'(d)) < XW'(count);
  assign sts.out_free   = !out_valid || out_ready;

  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_wa = '0;
    mem_ra = '0;
    mem_wd = '0;
    unique case (cmd)
      DP_INIT: begin
        mem_we = !heap_ready && sts.init_ok;
        mem_wd = {OW'(0), init_size_b[OW-1:0], 1'b1};
      end
      DP_SCAN_RD, DP_FIND_RD: begin
        mem_re = 1'b1;
        mem_ra = i[IW-1:0];
      end
      DP_SHU_RD: begin
        mem_re = 1'b1;
        mem_ra = km1[IW-1:0];
      end
      DP_SHU_WR, DP_SHD_WR: begin
        mem_we = 1'b1;
        mem_wa = k[IW-1:0];
        mem_wd = rdata;
      end
      DP_SPLIT: begin
        mem_we = 1'b1;
        mem_wa = ip1[IW-1:0];
        mem_wd = {split_start_b[OW-1:0], split_size_b[OW-1:0], 1'b1};
      end
      DP_MARK: begin
        mem_we = 1'b1;
        mem_wa = i[IW-1:0];
        mem_wd = {hit_start, mark_size, 1'b0};
      end
      DP_PREV_RD: begin
        mem_re = 1'b1;
        mem_ra = idx_m1[IW-1:0];
      end
      DP_NEXT_RD: begin
        mem_re = 1'b1;
        mem_ra = idx_p1[IW-1:0];
      end
      DP_MERGE_WR: begin
        mem_we = 1'b1;
        mem_wa = widx[IW-1:0];
        mem_wd = {base_start, acc, 1'b1};
      end
      DP_SHD_RD: begin
        mem_re = 1'b1;
        mem_ra = kpd[IW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rdata <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_ready <= 1'b0;
      heap_bytes <= '0;
      count      <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we && !heap_ready) heap_bytes <= cfg_data;
      if (cmd == DP_PUBLISH) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (cmd)
        DP_INIT: begin
          if (!heap_ready && sts.init_ok) begin
            count      <= CW'(1);
            heap_ready <= 1'b1;
          end
        end
        DP_SPLIT:   count <= count + CW'(1);
        DP_SHD_END: count <= count - CW'(d);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      DP_LOAD: begin
        op_r     <= op_t'(in_operation);
        req_r    <= in_request_bytes;
        pres_r   <= in_block_present;
        boff_r   <= in_block_offset;
        need_r   <= {need_sum[BW-1:ALIGN_BITS], ALIGN_BITS'(0)};
        status_r <= ST_OK;
        pay_r    <= '0;
        copy_r   <= '0;
        moved_r  <= 1'b0;
        moving   <= 1'b0;
      end
      DP_DECODE: if (sts.alloc_path && sts.req_zero) status_r <= ST_ZERO;
      DP_INIT: begin
        i <= '0;
        if (!heap_ready && !sts.init_ok) status_r <= ST_NOMEM;
      end
      DP_SCAN_EV: begin
        if (sts.scan_hit) begin
          hit_start <= rd_start;
          hit_size  <= rd_size;
          split_r   <= sts.split_ok;
          k         <= count;
        end else begin
          i <= ip1;
          if (sts.is_last) status_r <= ST_NOMEM;
        end
      end
      DP_SHU_WR: k <= km1;
      DP_MARK: begin
        pay_r <= hit_pay_x[FIELD_BITS-1:0];
        if (moving) begin
          moved_r <= 1'b1;
          copy_r  <= copy_b[FIELD_BITS-1:0];
        end
      end
      DP_FIND_START: begin
        i <= '0;
        if (count == '0) status_r <= ST_UNKNOWN;
      end
      DP_FIND_EV: begin
        if (sts.find_hit) begin
          idx        <= i;
          widx       <= i;
          base_start <= rd_start;
          acc        <= rd_size;
          d          <= 2'd0;
          // first lookup of a resize decides keep, shrink-to-free or move
          if (!moving && op_r != OP_FREE) begin
            if (sts.req_zero) status_r <= ST_ZERO;
            else if (sts.fits) pay_r <= boff_r;
            else begin
              moving   <= 1'b1;
              old_size <= rd_size;
            end
          end
        end else begin
          i <= ip1;
          if (sts.is_last) status_r <= ST_UNKNOWN;
        end
      end
      DP_PREV_EV: begin
        if (rd_free) begin
          acc        <= merge_sum[OW-1:0];
          base_start <= rd_start;
          widx       <= idx_m1;
          d          <= d + 2'd1;
        end
      end
      DP_NEXT_EV: begin
        if (rd_free) begin
          acc <= merge_sum[OW-1:0];
          d   <= d + 2'd1;
        end
      end
      DP_MERGE_WR: k <= widx + CW'(1);
      DP_SHD_WR:   k <= k + CW'(1);
      DP_PUBLISH: begin
        out_status         <= status_r;
        out_payload_offset <= pay_r;
        out_moved          <= moved_r;
        out_copy_bytes     <= copy_r;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[hw/rtl/ffha_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffha_ctrl
// Sequencer: walks the segment table and issues datapath commands.
// ----------------------------------------------------------------------------
module ffha_ctrl import ffha_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t sts,
  output dp_cmd_t    cmd
);

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_DECODE;
      S_DECODE: begin
        if (sts.alloc_path) state_next = sts.req_zero ? S_DONE : S_INIT;
        else if (sts.op == OP_FREE) state_next = sts.present ? S_FIND_START : S_DONE;
        else if (sts.op == OP_RESIZE) state_next = S_FIND_START;
        else state_next = S_DONE;
      end
      S_INIT: state_next = (sts.heap_ready || sts.init_ok) ? S_SCAN_RD : S_DONE;
      S_SCAN_RD: state_next = S_SCAN_EV;
      S_SCAN_EV: begin
        if (sts.scan_hit) begin
          if (sts.split_ok) state_next = sts.is_last ? S_SPLIT : S_SHU_RD;
          else state_next = S_MARK;
        end else begin
          state_next = sts.is_last ? S_DONE : S_SCAN_RD;
        end
      end
      S_SHU_RD: state_next = S_SHU_WR;
      S_SHU_WR: state_next = sts.shu_more ? S_SHU_RD : S_SPLIT;
      S_SPLIT: state_next = S_MARK;
      S_MARK: state_next = sts.moving ? S_FIND_START : S_DONE;
      S_FIND_START: state_next = sts.count_zero ? S_DONE : S_FIND_RD;
      S_FIND_RD: state_next = S_FIND_EV;
      S_FIND_EV: begin
        if (sts.find_hit) begin
          if (sts.moving || sts.op == OP_FREE || sts.req_zero) state_next = S_PREV_RD;
          else state_next = sts.fits ? S_DONE : S_INIT;
        end else begin
          state_next = sts.is_last ? S_DONE : S_FIND_RD;
        end
      end
      S_PREV_RD: state_next = sts.has_prev ? S_PREV_EV : S_NEXT_RD;
      S_PREV_EV: state_next = S_NEXT_RD;
      S_NEXT_RD: state_next = sts.has_next ? S_NEXT_EV : S_MERGE_WR;
      S_NEXT_EV: state_next = S_MERGE_WR;
      S_MERGE_WR: state_next = sts.shd_first ? S_SHD_RD : S_SHD_END;
      S_SHD_RD: state_next = S_SHD_WR;
      S_SHD_WR: state_next = sts.shd_more ? S_SHD_RD : S_SHD_END;
      S_SHD_END: state_next = S_DONE;
      S_DONE: if (sts.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = DP_IDLE;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd = DP_LOAD;
      end
      S_DECODE:     cmd = DP_DECODE;
      S_INIT:       cmd = DP_INIT;
      S_SCAN_RD:    cmd = DP_SCAN_RD;
      S_SCAN_EV:    cmd = DP_SCAN_EV;
      S_SHU_RD:     cmd = DP_SHU_RD;
      S_SHU_WR:     cmd = DP_SHU_WR;
      S_SPLIT:      cmd = DP_SPLIT;
      S_MARK:       cmd = DP_MARK;
      S_FIND_START: cmd = DP_FIND_START;
      S_FIND_RD:    cmd = DP_FIND_RD;
      S_FIND_EV:    cmd = DP_FIND_EV;
      S_PREV_RD:    cmd = DP_PREV_RD;
      S_PREV_EV:    cmd = DP_PREV_EV;
      S_NEXT_RD:    cmd = DP_NEXT_RD;
      S_NEXT_EV:    cmd = DP_NEXT_EV;
      S_MERGE_WR:   cmd = DP_MERGE_WR;
      S_SHD_RD:     cmd = DP_SHD_RD;
      S_SHD_WR:     cmd = DP_SHD_WR;
      S_SHD_END:    cmd = DP_SHD_END;
      S_DONE:       if (sts.out_free) cmd = DP_PUBLISH;
      default:      cmd = DP_IDLE;
    endcase
  end

endmodule
`default_nettype wire

[hw/rtl/first_fit_heap_allocator_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top
// First-fit allocator over an address-ordered segment table.
//
//   port     dir   handshake     word
//   req      in    valid/ready   operation, request_bytes, block_present,
//                                block_offset
//   rsp      out   valid/ready   status, payload_offset, moved, copy_bytes
//   cfg      in    cfg_we        cfg_data = heap_bytes
//
// One request at a time. Allocate: scan the table entries, move entries up
// on a split, then write the split and mark the hit. Free: scan the table
// to find the block, merge with free neighbors, then move entries down.
// A moving resize does both. Each table step goes through the single segment
// memory (one read and one write a cycle, registered read).
// No clearing pass: the table is empty after reset. The response sits in an
// output register; a stalled rsp holds the sequencer in its last state.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_top import ffha_pkg::*; #(
  parameter int MAX_SEGMENTS      = DEF_MAX_SEGMENTS,
  parameter int OFFSET_BITS       = DEF_OFFSET_BITS,
  parameter int HEADER_BYTES      = DEF_HEADER_BYTES,
  parameter int MIN_PAYLOAD_BYTES = DEF_MIN_PAYLOAD_BYTES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [FIELD_BITS-1:0] cfg_data,
  ffha_req_if.sink              req,
  ffha_rsp_if.source            rsp
);

  dp_cmd_t    cmd;
  dp_status_t sts;

  ffha_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ffha_dp #(
    .MAX_SEGMENTS      (MAX_SEGMENTS),
    .OFFSET_BITS       (OFFSET_BITS),
    .HEADER_BYTES      (HEADER_BYTES),
    .MIN_PAYLOAD_BYTES (MIN_PAYLOAD_BYTES)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_we             (cfg_we),
    .cfg_data           (cfg_data),
    .in_operation       (req.operation),
    .in_request_bytes   (req.request_bytes),
    .in_block_present   (req.block_present),
    .in_block_offset    (req.block_offset),
    .out_valid          (rsp.valid),
    .out_ready          (rsp.ready),
    .out_status         (rsp.status),
    .out_payload_offset (rsp.payload_offset),
    .out_moved          (rsp.moved),
    .out_copy_bytes     (rsp.copy_bytes)
  );

  // one request in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while busy");

  // result only lands in a free output register
  a_publish_free: assert property (@(posedge clk) disable iff (rst)
    (cmd == DP_PUBLISH) |-> (!rsp.valid || rsp.ready))
    else $error("response overwritten");

  // table walks and splits never run on an empty table
  a_table_nonempty: assert property (@(posedge clk) disable iff (rst)
    (cmd == DP_SCAN_RD || cmd == DP_SPLIT || cmd == DP_FIND_RD) |-> !sts.count_zero)
    else $error("table access with no segments");

endmodule
`default_nettype wire

[test/tb_first_fit_heap_allocator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_heap_allocator_top
// Self-checking bench for the first-fit heap allocator. Requests are queued
// by a stimulus process and sent by a clocked driver with random gaps. Each
// accepted request runs through a local model of the segment table. The
// monitor checks every response against the oldest predicted one.
// ----------------------------------------------------------------------------
module tb_first_fit_heap_allocator_top;
  import ffha_pkg::*;

  localparam int  SEGS     = 64;
  localparam int  HDR      = 24;
  localparam int  MIN_PAY  = 16;
  localparam longint unsigned OMASK = 64'hFF_FFFF;
  localparam int  LATENCY  = 600;
  localparam int  LIMIT    = 6_000_000;

  typedef struct {
    logic [1:0]  op;
    logic [23:0] req_bytes;
    logic        present;
    logic [23:0] offset;
  } alloc_req_t;

  typedef struct {
    logic [1:0]  status;
    logic [23:0] payload;
    logic        moved;
    logic [23:0] copy;
  } alloc_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [23:0] cfg_data = '0;

  ffha_req_if req ();
  ffha_rsp_if rsp ();

  first_fit_heap_allocator_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .req(req.sink), .rsp(rsp.source)
  );

  always #10 clk = ~clk;

  // local copy of the segment table
  longint unsigned seg_start [SEGS];
  longint unsigned seg_size [SEGS];
  bit              seg_free [SEGS];
  int              seg_cnt = 0;
  bit              heap_up = 0;
  longint unsigned heap_cfg = 0;

  alloc_req_t req_q [$];
  alloc_rsp_t rsp_exp_q [$];
  alloc_req_t cur;
  bit  req_fire = 0, rsp_fire = 0;
  bit  quiet = 0;
  int  gap_cnt = 0, rsp_wait = 0, rsp_hold = 0;
  int  mismatches = 0;
  longint cycles = 0;

  function automatic int draw_wait();
    return quiet ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic bit heap_setup();
    if (heap_up) return 1;
    if (heap_cfg <= HDR) return 0;
    seg_start[0] = 0;
    seg_size[0] = (heap_cfg - HDR) & OMASK;
    seg_free[0] = 1;
    seg_cnt = 1;
    heap_up = 1;
    return 1;
  endfunction

  function automatic longint first_fit(longint unsigned want);
    longint unsigned need;
    need = (want + 7) & ~64'd7;
    if (!heap_setup()) return -1;
    for (int i = 0; i < seg_cnt; i++) begin
      if (seg_free[i] && seg_size[i] >= need) begin
        if (seg_size[i] >= need + HDR + MIN_PAY && seg_cnt < SEGS) begin
          for (int k = seg_cnt; k > i + 1; k--) begin
            seg_start[k] = seg_start[k-1];
            seg_size[k] = seg_size[k-1];
            seg_free[k] = seg_free[k-1];
          end
          seg_start[i+1] = (seg_start[i] + HDR + need) & OMASK;
          seg_size[i+1] = seg_size[i] - need - HDR;
          seg_free[i+1] = 1;
          seg_size[i] = need;
          seg_cnt++;
        end
        seg_free[i] = 0;
        return longint'((seg_start[i] + HDR) & OMASK);
      end
    end
    return -1;
  endfunction

  function automatic int lookup(longint unsigned pay);
    for (int i = 0; i < seg_cnt; i++)
      if (((seg_start[i] + HDR) & OMASK) == pay) return i;
    return -1;
  endfunction

  function automatic void release_seg(int idx);
    int i;
    i = 0;
    seg_free[idx] = 1;
    while (i + 1 < seg_cnt) begin
      if (seg_free[i] && seg_free[i+1]) begin
        seg_size[i] = (seg_size[i] + HDR + seg_size[i+1]) & OMASK;
        for (int k = i + 1; k + 1 < seg_cnt; k++) begin
          seg_start[k] = seg_start[k+1];
          seg_size[k] = seg_size[k+1];
          seg_free[k] = seg_free[k+1];
        end
        seg_cnt--;
      end else begin
        i++;
      end
    end
  endfunction

  function automatic alloc_rsp_t heap_apply(alloc_req_t r);
    alloc_rsp_t o;
    longint res;
    longint unsigned old_size;
    int idx;
    o = '{status: ST_OK, payload: '0, moved: 1'b0, copy: '0};
    if (r.op == OP_ALLOC || (r.op == OP_RESIZE && !r.present)) begin
      if (r.req_bytes == 0) begin
        o.status = ST_ZERO;
      end else begin
        res = first_fit(r.req_bytes);
        if (res < 0) o.status = ST_NOMEM;
        else o.payload = res[23:0];
      end
    end else if (r.op == OP_FREE) begin
      if (r.present) begin
        idx = lookup(r.offset);
        if (idx < 0) o.status = ST_UNKNOWN;
        else release_seg(idx);
      end
    end else if (r.op == OP_RESIZE) begin
      idx = lookup(r.offset);
      if (idx < 0) begin
        o.status = ST_UNKNOWN;
      end else if (r.req_bytes == 0) begin
        release_seg(idx);
        o.status = ST_ZERO;
      end else if (seg_size[idx] >= r.req_bytes) begin
        o.payload = r.offset;
      end else begin
        old_size = seg_size[idx];
        res = first_fit(r.req_bytes);
        if (res < 0) begin
          o.status = ST_NOMEM;
        end else begin
          o.payload = res[23:0];
          o.moved = 1'b1;
          o.copy = (old_size < r.req_bytes) ? old_size[23:0] : r.req_bytes;
          idx = lookup(r.offset);
          if (idx >= 0) release_seg(idx);
        end
      end
    end
    return o;
  endfunction

  // accept side: register writes and requests update the model
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    if (!rst && cfg_we && !heap_up) heap_cfg = cfg_data;
    req_fire <= req.valid && req.ready;
    if (!rst && req.valid && req.ready) rsp_exp_q.push_back(heap_apply(cur));
  end

  // monitor
  always @(posedge clk) begin
    alloc_rsp_t e;
    rsp_fire <= rsp.valid && rsp.ready;
    if (!rst && rsp.valid && rsp.ready) begin
      if (rsp_exp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response word status=%0d", rsp.status);
      end else begin
        e = rsp_exp_q.pop_front();
        if (rsp.status !== e.status || rsp.payload_offset !== e.payload ||
            rsp.moved !== e.moved || rsp.copy_bytes !== e.copy) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d off=%h mv=%0d cp=%h got st=%0d off=%h mv=%0d cp=%h",
                     e.status, e.payload, e.moved, e.copy, rsp.status,
                     rsp.payload_offset, rsp.moved, rsp.copy_bytes);
        end
      end
    end
  end

  // driver
  always @(negedge clk) begin
    if (req.valid && !req_fire) begin
      // word still waiting for ready
    end else if (gap_cnt > 0) begin
      gap_cnt--;
      req.valid <= 1'b0;
    end else if (req_q.size() > 0) begin
      cur = req_q.pop_front();
      req.operation <= cur.op;
      req.request_bytes <= cur.req_bytes;
      req.block_present <= cur.present;
      req.block_offset <= cur.offset;
      req.valid <= 1'b1;
      gap_cnt = draw_wait();
    end else begin
      req.valid <= 1'b0;
    end
  end

  // response side back-pressure
  always @(negedge clk) begin
    bit rdy;
    if (rsp_fire) rsp_wait = draw_wait();
    if (rsp_hold > 0) begin
      rsp_hold--;
      rdy = 1'b0;
    end else if (rsp_wait > 0) begin
      rsp_wait--;
      rdy = 1'b0;
    end else begin
      rdy = 1'b1;
    end
    rsp.ready <= rdy;
  end

  task automatic send(logic [1:0] op, logic [23:0] nbytes, logic pres, logic [23:0] off);
    alloc_req_t r;
    r = '{op: op, req_bytes: nbytes, present: pres, offset: off};
    req_q.push_back(r);
  endtask

  task automatic drain();
    while (req_q.size() != 0 || req.valid || rsp_exp_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_heap(logic [23:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [23:0] pick_size();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return 24'($urandom_range(0, 24'hFF_FFFF));
      2: return 24'($urandom_range(200, 3000));
      default: return 24'($urandom_range(1, 160));
    endcase
  endfunction

  function automatic logic [23:0] pick_offset();
    int idx;
    if (seg_cnt > 0 && $urandom_range(0, 7) != 0) begin
      idx = $urandom_range(0, seg_cnt - 1);
      return 24'((seg_start[idx] + HDR) & OMASK);
    end
    return 24'($urandom_range(0, 24'hFF_FFFF));
  endfunction

  initial begin
    int pick;
    op_t op;
    req.valid = 1'b0;
    req.operation = '0;
    req.request_bytes = '0;
    req.block_present = 1'b0;
    req.block_offset = '0;
    rsp.ready = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // heap not yet usable
    write_heap(24'hFF_FFFF);
    write_heap(24'd0);
    send(OP_ALLOC, 24'd8, 1'b0, '0);
    send(OP_ALLOC, 24'd0, 1'b0, '0);
    send(OP_NOP, 24'hFF_FFFF, 1'b1, 24'hFF_FFFF);
    send(OP_FREE, 24'd0, 1'b0, '0);
    send(OP_FREE, 24'd0, 1'b1, 24'd24);
    drain();
    write_heap(24'd24);  // header only: still too small
    send(OP_RESIZE, 24'd16, 1'b0, '0);
    drain();

    write_heap(24'd8192);
    send(OP_ALLOC, 24'd1, 1'b0, '0);            // at 24
    send(OP_ALLOC, 24'd16, 1'b0, '0);           // at 56
    send(OP_ALLOC, 24'hFF_FFFF, 1'b0, '0);
    send(OP_FREE, 24'd0, 1'b1, 24'd24);
    send(OP_FREE, 24'd0, 1'b1, 24'd24);         // already free
    send(OP_RESIZE, 24'd12, 1'b1, 24'd56);      // fits in place
    send(OP_RESIZE, 24'd100, 1'b1, 24'd56);     // moves
    send(OP_RESIZE, 24'hFF_FFFF, 1'b1, 24'd24);
    send(OP_RESIZE, 24'd40, 1'b1, 24'd57);      // unknown
    send(OP_RESIZE, 24'd0, 1'b1, 24'd24);
    send(OP_RESIZE, 24'd0, 1'b1, 24'd999);
    drain();
    write_heap(24'hFF_FFFF);  // ignored once the heap is set up
    write_heap(24'd0);

    for (int n = 0; n < 1000; n++) begin
      if (n % 250 == 0) begin
        drain();
        quiet = (n == 500);
      end
      if (n == 300) rsp_hold = 400;
      while (req_q.size() >= 2) @(posedge clk);
      pick = $urandom_range(0, 99);
      op = pick < 40 ? OP_ALLOC : pick < 70 ? OP_FREE : pick < 95 ? OP_RESIZE : OP_NOP;
      send(op, pick_size(), $urandom_range(0, 9) != 0, pick_offset());
    end
    drain();
    if (mismatches == 0 && rsp_exp_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
